// ===== rtl/sparc_integer_execute_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SPARC_INTEGER_EXECUTE_UNIT_DEFINES_SVH
`define SPARC_INTEGER_EXECUTE_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SIEU_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SIEU_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// ===== rtl/sieu_pkg.sv =====
// ----------------------------------------------------------------------------
// sieu_pkg
// Types and codes for the integer execute unit.
// ----------------------------------------------------------------------------
package sieu_pkg;

  typedef enum logic [4:0] {
    OP_CALL = 5'd0, OP_SETHI = 5'd1, OP_NOP = 5'd2, OP_BRANCH = 5'd3,
    OP_ADD = 5'd4, OP_SUB = 5'd5, OP_SUBCC = 5'd6, OP_UMUL = 5'd7,
    OP_UDIV = 5'd8, OP_AND = 5'd9, OP_ANDCC = 5'd10, OP_OR = 5'd11,
    OP_XNOR = 5'd12, OP_SLL = 5'd13, OP_SRL = 5'd14, OP_SAVE = 5'd15,
    OP_RESTORE = 5'd16, OP_WR = 5'd17, OP_JMPL = 5'd18, OP_UNIMP = 5'd19
  } op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;

  localparam logic [3:0] CC_ALWAYS = 4'd8;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [3:0]  cond_code;
    logic        annul_bit;
    logic [31:0] rs1_value;
    logic [31:0] operand2;
    logic [31:0] target_address;
  } in_req_t;

  typedef struct packed {
    logic [31:0] rd_value;
    logic        rd_write;
    logic [31:0] next_pc;
    logic [31:0] next_npc;
    logic [3:0]  icc_flags;
    logic [31:0] y_value;
    logic [1:0]  status;
  } out_req_t;

endpackage

// ===== rtl/sparc_integer_execute_unit.sv =====
// ----------------------------------------------------------------------------
// sparc_integer_execute_unit
// Executes one decoded integer instruction and keeps pc, npc, y and icc.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready take one decoded request (in_data). The result leaves
//   on out_valid/out_ready (out_data), one result per request.
//   Simple operations and udiv by zero go from the accept to S_DONE, which
//   loads the output register and raises out_valid. umul runs a shift-add
//   loop on one shared adder, 32 iterations, and udiv runs a restoring
//   divide on the same adder, 32 iterations; both then pass S_DONE into the
//   output register.
//   in_ready is high only while no request is in work and the output
//   register is empty or being drained, so one request is in flight: a new
//   request is not taken until the last one has reached the output
//   register.
//   A stalled receiver holds the result in the output register; no new
//   request is taken until it is drained.
//   Reset (rst_n low, synchronous) sets pc 0, npc 4, y 0, icc 0 and
//   drops any request in work.
// ----------------------------------------------------------------------------
module sparc_integer_execute_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sieu_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sieu_pkg::out_req_t out_data
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

  state_t             state_r;
  sieu_pkg::in_req_t  req_r;
  logic [31:0]        pc_r, npc_r, y_r;
  logic [3:0]         icc_r;
  logic [31:0]        acc_r;   // mul: high partial; div: remainder
  logic [31:0]        lo_r;    // mul: low/multiplier; div: quotient
  logic [31:0]        dlo_r;   // div: remaining dividend bits
  logic               sat_r;
  logic [4:0]         cnt_r;
  logic               out_valid_r;
  sieu_pkg::out_req_t out_r;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Divide step operand: remainder shifted left with the next dividend bit
  logic [32:0] dshift;
  assign dshift = {acc_r, dlo_r[31]};

  // Shared adder: mul adds rs1, div trial-subtracts operand2
  logic [33:0] add_a, add_b, add_s;
  logic        add_cin;
  logic        dge;
  always_comb begin
    if (state_r == S_DIV) begin
      add_a   = {1'b0, dshift};
      add_b   = ~{2'b00, req_r.operand2};
      add_cin = 1'b1;
    end else begin
      add_a   = {2'b00, acc_r};
      add_b   = lo_r[0] ? {2'b00, req_r.rs1_value} : 34'd0;
      add_cin = 1'b0;
    end
    add_s = add_a + add_b + {33'd0, add_cin};
  end
  // No borrow out of the trial subtract: shifted remainder >= divisor
  assign dge = ~add_s[33];

  // Combinational result for the simple operations
  sieu_pkg::out_req_t simple;
  logic [31:0] subr, npc4;
  logic        n, z, v, c, take, sa, sb, sr;
  logic [3:0]  cc;
  always_comb begin
    npc4 = npc_r + 32'd4;
    subr = req_r.rs1_value - req_r.operand2;
    n = icc_r[3]; z = icc_r[2]; v = icc_r[1]; c = icc_r[0];
    cc = req_r.cond_code;
    case (cc[2:0])
      3'd0:    take = 1'b0;
      3'd1:    take = z;
      3'd2:    take = z | (n ^ v);
      3'd3:    take = n ^ v;
      3'd4:    take = c | z;
      3'd5:    take = c;
      3'd6:    take = n;
      default: take = v;
    endcase
    take = take ^ cc[3];
    sa = req_r.rs1_value[31]; sb = req_r.operand2[31]; sr = subr[31];
    simple.rd_value  = 32'd0;
    simple.rd_write  = 1'b1;
    simple.next_pc   = npc_r;
    simple.next_npc  = npc4;
    simple.icc_flags = icc_r;
    simple.y_value   = y_r;
    simple.status    = sieu_pkg::ST_OK;
    case (req_r.req_type)
      sieu_pkg::OP_CALL: begin
        simple.rd_value = pc_r;
        simple.next_npc = req_r.target_address;
      end
      sieu_pkg::OP_SETHI: simple.rd_value = req_r.operand2;
      sieu_pkg::OP_NOP:   simple.rd_write = 1'b0;
      sieu_pkg::OP_BRANCH: begin
        simple.rd_write = 1'b0;
        if (req_r.annul_bit && cc == sieu_pkg::CC_ALWAYS) begin
          simple.next_pc  = req_r.target_address;
          simple.next_npc = req_r.target_address + 32'd4;
        end else if (take) begin
          simple.next_npc = req_r.target_address;
        end else if (req_r.annul_bit) begin
          simple.next_pc  = npc4;
          simple.next_npc = npc_r + 32'd8;
        end
      end
      sieu_pkg::OP_ADD, sieu_pkg::OP_SAVE, sieu_pkg::OP_RESTORE:
        simple.rd_value = req_r.rs1_value + req_r.operand2;
      sieu_pkg::OP_SUB: simple.rd_value = subr;
      sieu_pkg::OP_SUBCC: begin
        simple.rd_value  = subr;
        simple.icc_flags = {sr, subr == 32'd0,
                            (sa & ~sb & ~sr) | (~sa & sb & sr),
                            (~sa & sb) | (sr & (~sa | sb))};
      end
      sieu_pkg::OP_AND: simple.rd_value = req_r.rs1_value & req_r.operand2;
      sieu_pkg::OP_ANDCC: begin
        simple.rd_value  = req_r.rs1_value & req_r.operand2;
        simple.icc_flags = {simple.rd_value[31], simple.rd_value == 32'd0, 2'b00};
      end
      sieu_pkg::OP_OR:   simple.rd_value = req_r.rs1_value | req_r.operand2;
      sieu_pkg::OP_XNOR: simple.rd_value = ~(req_r.rs1_value ^ req_r.operand2);
      sieu_pkg::OP_SLL:  simple.rd_value = req_r.rs1_value << req_r.operand2[4:0];
      sieu_pkg::OP_SRL:  simple.rd_value = req_r.rs1_value >> req_r.operand2[4:0];
      sieu_pkg::OP_WR:   simple.rd_value = req_r.rs1_value ^ req_r.operand2;
      sieu_pkg::OP_JMPL: begin
        simple.rd_value = pc_r;
        simple.next_npc = req_r.rs1_value + req_r.operand2;
      end
      default: begin
        simple.rd_write = 1'b0;
        simple.next_pc  = pc_r;
        simple.next_npc = npc_r;
        simple.status   = sieu_pkg::ST_ILLEGAL;
      end
    endcase
  end

  // Sequencer, architectural state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= 32'd0;
      npc_r       <= 32'd4;
      y_r         <= 32'd0;
      icc_r       <= 4'd0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req_r  <= in_data;
            // div starts its remainder from y; multiplier goes in lo_r
            acc_r  <= (in_data.req_type == sieu_pkg::OP_UDIV) ? y_r : 32'd0;
            lo_r   <= (in_data.req_type == sieu_pkg::OP_UMUL) ? in_data.operand2 : 32'd0;
            dlo_r  <= in_data.rs1_value;
            cnt_r  <= 5'd0;
            // check saturation: y >= divisor means quotient overflows
            sat_r  <= (y_r >= in_data.operand2);
            if (in_data.req_type == sieu_pkg::OP_UMUL) begin
              state_r <= S_MUL;
            end else if (in_data.req_type == sieu_pkg::OP_UDIV &&
                         in_data.operand2 != 32'd0) begin
              state_r <= S_DIV;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MUL: begin
          // Add then shift the 64-bit {acc, lo} right one place
          acc_r <= add_s[32:1];
          lo_r  <= {add_s[0], lo_r[31:1]};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= S_DONE;
        end
        S_DIV: begin
          // Restoring step on {acc, dlo}; quotient bit into lo
          acc_r <= dge ? add_s[31:0] : dshift[31:0];
          lo_r  <= {lo_r[30:0], dge};
          dlo_r <= {dlo_r[30:0], 1'b0};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= S_DONE;
        end
        S_DONE: begin
          if (req_r.req_type == sieu_pkg::OP_UMUL) begin
            out_r <= '{rd_value: lo_r, rd_write: 1'b1, next_pc: npc_r,
                       next_npc: npc_r + 32'd4, icc_flags: icc_r, y_value: acc_r,
                       status: sieu_pkg::ST_OK};
            y_r   <= acc_r;
            pc_r  <= npc_r;
            npc_r <= npc_r + 32'd4;
          end else if (req_r.req_type == sieu_pkg::OP_UDIV) begin
            if (req_r.operand2 == 32'd0) begin
              out_r <= '{rd_value: 32'd0, rd_write: 1'b0, next_pc: pc_r,
                         next_npc: npc_r, icc_flags: icc_r, y_value: y_r,
                         status: sieu_pkg::ST_DIVZERO};
            end else begin
              out_r <= '{rd_value: sat_r ? 32'hFFFF_FFFF : lo_r, rd_write: 1'b1,
                         next_pc: npc_r, next_npc: npc_r + 32'd4, icc_flags: icc_r,
                         y_value: y_r, status: sieu_pkg::ST_OK};
              pc_r  <= npc_r;
              npc_r <= npc_r + 32'd4;
            end
          end else begin
            out_r <= simple;
            pc_r  <= simple.next_pc;
            npc_r <= simple.next_npc;
            icc_r <= simple.icc_flags;
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sieu_checker.sv =====
// ----------------------------------------------------------------------------
// sieu_checker
// Port-level checks for the integer execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "sparc_integer_execute_unit_defines.svh"

module sieu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sieu_pkg::out_req_t out_data
);

  // A stalled result holds
  `SIEU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // No new request while a result waits undrained
  `SIEU_ASSERT_IMP(a_no_accept_full, clk, rst_n, out_valid && !out_ready, !in_ready)
  // An accepted request blocks the input next cycle
  `SIEU_ASSERT_NXT(a_one_inflight, clk, rst_n, in_valid && in_ready, !in_ready)
  // Write flag only with ok status
  `SIEU_ASSERT_IMP(a_wr_ok, clk, rst_n, out_valid && out_data.rd_write, out_data.status == 2'd0)

endmodule

bind sparc_integer_execute_unit sieu_checker u_sieu_checker (.*);

// ===== dv/sparc_integer_execute_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparc_integer_execute_unit_tb
// Drives decoded integer instructions with random gaps and output stalls,
// predicts pc, npc, y, icc and the destination value for every request, and
// compares each result field by field.
// ----------------------------------------------------------------------------
module sparc_integer_execute_unit_tb;

  localparam int WATCHDOG_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sieu_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sieu_pkg::out_req_t out_data;

  // architectural state kept by the predictor
  logic [31:0]        pred_pc, pred_npc, pred_y;
  logic [3:0]         pred_icc;
  sieu_pkg::out_req_t exp_results[$];
  int                 fail_cnt = 0;
  int                 idle_cycles = 0;
  bit                 out_stall_on = 1'b1;

  sparc_integer_execute_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // evaluate a branch condition against the current flags
  function automatic bit branch_taken(logic [3:0] cc, logic [3:0] f);
    bit r;
    case (cc[2:0])
      3'd0: r = 1'b0;
      3'd1: r = f[2];
      3'd2: r = f[2] | (f[3] ^ f[1]);
      3'd3: r = f[3] ^ f[1];
      3'd4: r = f[0] | f[2];
      3'd5: r = f[0];
      3'd6: r = f[3];
      default: r = f[1];
    endcase
    return cc[3] ? ~r : r;
  endfunction

  // advance the architectural state and produce the expected result
  function automatic sieu_pkg::out_req_t execute_instr(sieu_pkg::in_req_t rq);
    sieu_pkg::out_req_t res;
    logic [31:0] a, b, r, npc_seq;
    logic [63:0] prod, dvd, quo;
    bit          sa, sb, sr;
    a = rq.rs1_value;
    b = rq.operand2;
    npc_seq = pred_npc + 32'd4;
    res = '0;
    res.next_pc = pred_npc;
    res.next_npc = npc_seq;
    case (rq.req_type)
      sieu_pkg::OP_CALL: begin
        res.rd_value = pred_pc; res.rd_write = 1'b1; res.next_npc = rq.target_address;
      end
      sieu_pkg::OP_SETHI: begin
        res.rd_value = b; res.rd_write = 1'b1;
      end
      sieu_pkg::OP_NOP: ;
      sieu_pkg::OP_BRANCH: begin
        if (rq.annul_bit) begin
          if (rq.cond_code == sieu_pkg::CC_ALWAYS) begin
            res.next_pc = rq.target_address;
            res.next_npc = rq.target_address + 32'd4;
          end else if (branch_taken(rq.cond_code, pred_icc)) begin
            res.next_npc = rq.target_address;
          end else begin
            res.next_pc = pred_npc + 32'd4;
            res.next_npc = pred_npc + 32'd8;
          end
        end else if (branch_taken(rq.cond_code, pred_icc)) begin
          res.next_npc = rq.target_address;
        end
      end
      sieu_pkg::OP_ADD, sieu_pkg::OP_SAVE, sieu_pkg::OP_RESTORE: begin
        res.rd_value = a + b; res.rd_write = 1'b1;
      end
      sieu_pkg::OP_SUB: begin
        res.rd_value = a - b; res.rd_write = 1'b1;
      end
      sieu_pkg::OP_SUBCC: begin
        r = a - b;
        sa = a[31]; sb = b[31]; sr = r[31];
        pred_icc = {sr, r == 32'd0, (sa & ~sb & ~sr) | (~sa & sb & sr),
                    (~sa & sb) | (sr & (~sa | sb))};
        res.rd_value = r; res.rd_write = 1'b1;
      end
      sieu_pkg::OP_UMUL: begin
        prod = {32'd0, a} * {32'd0, b};
        pred_y = prod[63:32];
        res.rd_value = prod[31:0]; res.rd_write = 1'b1;
      end
      sieu_pkg::OP_UDIV: begin
        if (b == 32'd0) begin
          res.status = sieu_pkg::ST_DIVZERO;
          res.next_pc = pred_pc;
          res.next_npc = pred_npc;
        end else begin
          dvd = {pred_y, a};
          quo = dvd / {32'd0, b};
          res.rd_value = (quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo[31:0];
          res.rd_write = 1'b1;
        end
      end
      sieu_pkg::OP_AND: begin
        res.rd_value = a & b; res.rd_write = 1'b1;
      end
      sieu_pkg::OP_ANDCC: begin
        r = a & b;
        pred_icc = {r[31], r == 32'd0, 2'b00};
        res.rd_value = r; res.rd_write = 1'b1;
      end
      sieu_pkg::OP_OR: begin
        res.rd_value = a | b; res.rd_write = 1'b1;
      end
      sieu_pkg::OP_XNOR: begin
        res.rd_value = ~(a ^ b); res.rd_write = 1'b1;
      end
      sieu_pkg::OP_SLL: begin
        res.rd_value = a << b[4:0]; res.rd_write = 1'b1;
      end
      sieu_pkg::OP_SRL: begin
        res.rd_value = a >> b[4:0]; res.rd_write = 1'b1;
      end
      sieu_pkg::OP_WR: begin
        res.rd_value = a ^ b; res.rd_write = 1'b1;
      end
      sieu_pkg::OP_JMPL: begin
        res.rd_value = pred_pc; res.rd_write = 1'b1; res.next_npc = a + b;
      end
      default: begin
        res.status = sieu_pkg::ST_ILLEGAL;
        res.next_pc = pred_pc;
        res.next_npc = pred_npc;
      end
    endcase
    pred_pc = res.next_pc;
    pred_npc = res.next_npc;
    res.icc_flags = pred_icc;
    res.y_value = pred_y;
    return res;
  endfunction

  // send one request after a random gap; predict its result on accept
  task automatic send_request(sieu_pkg::in_req_t rq, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (!in_ready);
    exp_results.push_back(execute_instr(rq));
    @(negedge clk);
  endtask

  function automatic sieu_pkg::in_req_t make_req(logic [4:0] op, logic [31:0] a,
                                                 logic [31:0] b);
    sieu_pkg::in_req_t rq;
    rq.req_type = op;
    rq.cond_code = 4'($urandom_range(0, 15));
    rq.annul_bit = 1'($urandom_range(0, 1));
    rq.rs1_value = a;
    rq.operand2 = b;
    rq.target_address = $urandom;
    return rq;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  // drop the request and hold the sender until every result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (exp_results.size() == 0);
    @(negedge clk);
  endtask

  // all-ones operands for each operation, plus flag, divide-by-zero, illegal and shift cases
  task automatic test_directed_ops();
    for (int op = 0; op < 20; op++) begin
      send_request(make_req(5'(op), 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    end
    send_request(make_req(sieu_pkg::OP_SUBCC, 32'h8000_0000, 32'd1));
    send_request(make_req(sieu_pkg::OP_SUBCC, 32'd5, 32'd5));
    send_request(make_req(sieu_pkg::OP_UDIV, 32'd100, 32'd0));
    send_request(make_req(5'd31, 32'd0, 32'd0));
    send_request(make_req(sieu_pkg::OP_SLL, 32'd1, 32'hFFFF_FFE1));
  endtask

  // every condition with and without annul after flag-setting ops
  task automatic test_branches();
    sieu_pkg::in_req_t rq;
    for (int i = 0; i < 96; i++) begin
      send_request(make_req(($urandom_range(0, 1)) ? sieu_pkg::OP_SUBCC
                                                   : sieu_pkg::OP_ANDCC,
                            rand_word(), rand_word()));
      rq = make_req(sieu_pkg::OP_BRANCH, 32'd0, 32'd0);
      rq.cond_code = 4'(i % 16);
      rq.annul_bit = 1'((i / 16) % 2);
      send_request(rq);
    end
  endtask

  // umul then udiv so the quotient uses a live high word, saturation included
  task automatic test_mul_div();
    for (int i = 0; i < 60; i++) begin
      send_request(make_req(sieu_pkg::OP_UMUL, rand_word(), rand_word()));
      send_request(make_req(sieu_pkg::OP_UDIV, rand_word(), rand_word()));
    end
  endtask

  // random mix over the whole opcode space, stall-free stretches included
  task automatic test_random_mix();
    sieu_pkg::in_req_t rq;
    for (int i = 0; i < 800; i++) begin
      if (i == 400) drain_results();
      out_stall_on = !(i >= 200 && i < 300);
      rq = make_req(($urandom_range(0, 9) == 0) ? 5'($urandom_range(19, 31))
                                                : 5'($urandom_range(0, 18)),
                    rand_word(), rand_word());
      if ($urandom_range(0, 3) == 0) rq.target_address = rand_word();
      send_request(rq, !out_stall_on);
    end
    out_stall_on = 1'b1;
  endtask

  // result receiver with random stalls
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      stall = out_stall_on ? $urandom_range(0, 14) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    sieu_pkg::out_req_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (exp_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        fail_cnt++;
      end else begin
        exp_res = exp_results.pop_front();
        if (out_data !== exp_res) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_res, out_data);
          $display("  rd %h/%h wr %b/%b pc %h/%h npc %h/%h icc %h/%h y %h/%h st %0d/%0d",
                   exp_res.rd_value, out_data.rd_value, exp_res.rd_write,
                   out_data.rd_write, exp_res.next_pc, out_data.next_pc,
                   exp_res.next_npc, out_data.next_npc, exp_res.icc_flags,
                   out_data.icc_flags, exp_res.y_value, out_data.y_value,
                   exp_res.status, out_data.status);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    pred_pc = 32'd0;
    pred_npc = 32'd4;
    pred_y = 32'd0;
    pred_icc = 4'd0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_branches();
    test_mul_div();
    test_random_mix();
    drain_results();
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
